### rtl/bts_pkg.sv
`timescale 1ns / 1ps

package bts_pkg;

   localparam int SIZE_BITS = 24;
   localparam int LEN_BITS  = 13;
   localparam int CRC_BITS  = 32;
   localparam logic [LEN_BITS-1:0] MAX_BLOCK = 13'd4096;
   localparam logic [LEN_BITS-1:0] BLOCK_LENGTH_RESET = 13'd4096;

   localparam logic [7:0] SID_TRANSFER_DATA     = 8'h36;
   localparam logic [7:0] SID_TRANSFER_DATA_POS = 8'h76;
   localparam logic [CRC_BITS-1:0] CRC_POLY     = 32'hEDB88320;

   // configuration register indexes
   localparam logic CSR_BLOCK_LENGTH = 1'b0;
   localparam logic CSR_CLAIMED      = 1'b1;

   // report status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_ARG     = 3'd1;
   localparam logic [2:0] ST_NOT_CLAIMED = 3'd2;
   localparam logic [2:0] ST_READ_FAILED = 3'd3;
   localparam logic [2:0] ST_REJECTED    = 3'd4;
   localparam logic [2:0] ST_BAD_RESP    = 3'd5;

   localparam logic KIND_FRAME  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // output queue depth and the most results one transaction can cause
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = 2;
   localparam int RSP_CNT_BITS = 3;
   localparam int MAX_RESULTS  = 3;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_DATA  = 2'd1,
      ACT_RESP  = 2'd2,
      ACT_FAIL  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_FILL = 2'd1,
      PH_WAIT = 2'd2
   } phase_type;

   typedef struct packed {
      logic                  kind;
      logic [7:0]            frame_byte;
      logic                  frame_end;
      logic [2:0]            status;
      logic [SIZE_BITS-1:0]  bytes_sent;
      logic [SIZE_BITS-1:0]  blocks_done;
      logic [7:0]            last_counter;
      logic [CRC_BITS-1:0]   checksum;
      logic                  run_last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                        count;
      rsp_item_type [MAX_RESULTS-1:0]    item;
   } rsp_push_type;

endpackage

### rtl/block_transfer_sender_with_crc.sv
`timescale 1ns / 1ps
// the first result of a transaction is valid in the cycle after it is accepted
// throughput: one transaction per cycle; a data byte that opens a block yields three
// results, so the input stalls while the four-entry result queue drains
// sustained rate, set by the single result port: one result per cycle unless stalled
// reset: synchronous, clears the transfer state and queue, restores the configuration

module block_transfer_sender_with_crc (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [bts_pkg::SIZE_BITS-1:0]  req_total_size,
   input  logic [7:0]                     req_first_counter,
   input  logic [7:0]                     req_data_byte,
   input  logic [4:0]                     req_resp_length,
   input  logic [7:0]                     req_resp_first,
   input  logic [7:0]                     req_resp_second,
   input  logic                           req_resp_negative,
   input  logic                           req_link_error,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_kind,
   output logic [7:0]                     rsp_frame_byte,
   output logic                           rsp_frame_end,
   output logic [2:0]                     rsp_status,
   output logic [bts_pkg::SIZE_BITS-1:0]  rsp_bytes_sent,
   output logic [bts_pkg::SIZE_BITS-1:0]  rsp_blocks_done,
   output logic [7:0]                     rsp_last_counter,
   output logic [bts_pkg::CRC_BITS-1:0]   rsp_checksum,
   output logic                           rsp_run_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [bts_pkg::LEN_BITS-1:0]   csr_data
);

   bts_pkg::rsp_push_type push;
   bts_pkg::rsp_item_type head;
   logic                  room;
   logic                  accept;

   assign csr_ready = 1'b1;
   assign req_stall = !room;
   assign accept    = req_valid && room;

   bts_core u_core (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_action        (req_action),
      .req_total_size    (req_total_size),
      .req_first_counter (req_first_counter),
      .req_data_byte     (req_data_byte),
      .req_resp_length   (req_resp_length),
      .req_resp_first    (req_resp_first),
      .req_resp_second   (req_resp_second),
      .req_resp_negative (req_resp_negative),
      .req_link_error    (req_link_error),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .push              (push)
   );

   bts_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (!rsp_stall),
      .not_empty (rsp_valid),
      .room      (room),
      .head      (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_frame_byte   = head.frame_byte;
   assign rsp_frame_end    = head.frame_end;
   assign rsp_status       = head.status;
   assign rsp_bytes_sent   = head.bytes_sent;
   assign rsp_blocks_done  = head.blocks_done;
   assign rsp_last_counter = head.last_counter;
   assign rsp_checksum     = head.checksum;
   assign rsp_run_last     = head.run_last;

endmodule

### rtl/bts_core.sv
`timescale 1ns / 1ps

module bts_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [1:0]                    req_action,
   input  logic [bts_pkg::SIZE_BITS-1:0] req_total_size,
   input  logic [7:0]                    req_first_counter,
   input  logic [7:0]                    req_data_byte,
   input  logic [4:0]                    req_resp_length,
   input  logic [7:0]                    req_resp_first,
   input  logic [7:0]                    req_resp_second,
   input  logic                          req_resp_negative,
   input  logic                          req_link_error,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [bts_pkg::LEN_BITS-1:0]  csr_data,
   output bts_pkg::rsp_push_type         push
);

   localparam int SB = bts_pkg::SIZE_BITS;
   localparam int LB = bts_pkg::LEN_BITS;
   localparam int CB = bts_pkg::CRC_BITS;

   logic [LB-1:0]     block_length_ff;
   logic              claimed_ff;

   bts_pkg::phase_type phase_ff, phase_in;
   logic [7:0]        counter_ff, counter_in;
   logic [SB-1:0]     offset_ff, offset_in;
   logic [SB-1:0]     file_size_ff, file_size_in;
   logic [LB-1:0]     fill_ff, fill_in;
   logic [LB-1:0]     goal_ff, goal_in;
   logic [CB-1:0]     committed_ff, committed_in;
   logic [CB-1:0]     pending_ff, pending_in;
   logic [SB-1:0]     sent_ff, sent_in;
   logic [SB-1:0]     blocks_ff, blocks_in;
   logic [7:0]        last_cnt_ff, last_cnt_in;
   logic [LB-1:0]     latched_ff, latched_in;

   logic [SB-1:0]     next_offset;
   logic [SB-1:0]     next_rem;
   logic [LB-1:0]     next_fill;
   logic              resp_ok;
   logic              bad_len;

   function automatic logic [CB-1:0] crc_byte(input logic [CB-1:0] crc, input logic [7:0] b);
      logic [CB-1:0] c;
      c = ~crc ^ {{(CB-8){1'b0}}, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? bts_pkg::CRC_POLY : {CB{1'b0}});
      end
      return ~c;
   endfunction

   function automatic bts_pkg::rsp_item_type make_frame(input logic [7:0] b, input logic fin,
                                                        input logic last);
      bts_pkg::rsp_item_type r;
      r            = '0;
      r.kind       = bts_pkg::KIND_FRAME;
      r.frame_byte = b;
      r.frame_end  = fin;
      r.run_last   = last;
      return r;
   endfunction

   function automatic bts_pkg::rsp_item_type make_report(
      input logic [2:0] st, input logic [SB-1:0] sent, input logic [SB-1:0] blocks,
      input logic [7:0] last_cnt, input logic [CB-1:0] crc);
      bts_pkg::rsp_item_type r;
      r              = '0;
      r.kind         = bts_pkg::KIND_REPORT;
      r.status       = st;
      r.bytes_sent   = sent;
      r.blocks_done  = blocks;
      r.last_counter = last_cnt;
      r.checksum     = crc;
      r.run_last     = 1'b1;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= bts_pkg::BLOCK_LENGTH_RESET;
         claimed_ff      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            bts_pkg::CSR_BLOCK_LENGTH: block_length_ff <= csr_data;
            bts_pkg::CSR_CLAIMED:      claimed_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign next_offset = offset_ff + {{(SB-LB){1'b0}}, goal_ff};
   assign next_rem    = file_size_ff - next_offset;
   assign next_fill   = fill_ff + 1'b1;
   assign bad_len     = (block_length_ff == '0) || (block_length_ff > bts_pkg::MAX_BLOCK);
   // echo of the counter only checked when a second byte is present
   assign resp_ok     = !req_link_error && (req_resp_length != 5'd0)
                        && (req_resp_first == bts_pkg::SID_TRANSFER_DATA_POS)
                        && !((req_resp_length >= 5'd2) && (req_resp_second != counter_ff))
                        && !req_resp_negative;

   always_comb begin
      phase_in     = phase_ff;
      counter_in   = counter_ff;
      offset_in    = offset_ff;
      file_size_in = file_size_ff;
      fill_in      = fill_ff;
      goal_in      = goal_ff;
      committed_in = committed_ff;
      pending_in   = pending_ff;
      sent_in      = sent_ff;
      blocks_in    = blocks_ff;
      last_cnt_in  = last_cnt_ff;
      latched_in   = latched_ff;
      push         = '0;
      if (accept) begin
         case (bts_pkg::action_type'(req_action))
            bts_pkg::ACT_START: begin
               phase_in = bts_pkg::PH_IDLE;
               if (req_total_size == '0 || bad_len) begin
                  push.count   = 2'd1;
                  push.item[0] = make_report(bts_pkg::ST_BAD_ARG, '0, '0, '0, '0);
               end else if (!claimed_ff) begin
                  push.count   = 2'd1;
                  push.item[0] = make_report(bts_pkg::ST_NOT_CLAIMED, '0, '0, '0, '0);
               end else begin
                  counter_in   = req_first_counter;
                  offset_in    = '0;
                  file_size_in = req_total_size;
                  committed_in = '0;
                  pending_in   = '0;
                  sent_in      = '0;
                  blocks_in    = '0;
                  last_cnt_in  = '0;
                  latched_in   = block_length_ff;
                  fill_in      = '0;
                  goal_in      = (req_total_size < {{(SB-LB){1'b0}}, block_length_ff})
                                 ? req_total_size[LB-1:0] : block_length_ff;
                  phase_in     = bts_pkg::PH_FILL;
               end
            end
            bts_pkg::ACT_DATA: begin
               if (phase_ff == bts_pkg::PH_FILL) begin
                  pending_in = crc_byte(pending_ff, req_data_byte);
                  fill_in    = next_fill;
                  if (next_fill >= goal_ff) begin
                     phase_in = bts_pkg::PH_WAIT;
                  end
                  // a block opens with the service id and the counter
                  if (fill_ff == '0) begin
                     push.count   = 2'd3;
                     push.item[0] = make_frame(bts_pkg::SID_TRANSFER_DATA, 1'b0, 1'b0);
                     push.item[1] = make_frame(counter_ff, 1'b0, 1'b0);
                     push.item[2] = make_frame(req_data_byte, next_fill >= goal_ff, 1'b1);
                  end else begin
                     push.count   = 2'd1;
                     push.item[0] = make_frame(req_data_byte, next_fill >= goal_ff, 1'b1);
                  end
               end
            end
            bts_pkg::ACT_RESP: begin
               if (phase_ff == bts_pkg::PH_WAIT) begin
                  blocks_in   = blocks_ff + 1'b1;
                  last_cnt_in = counter_ff;
                  push.count  = 2'd0;
                  if (!resp_ok) begin
                     phase_in     = bts_pkg::PH_IDLE;
                     push.count   = 2'd1;
                     push.item[0] = make_report(req_resp_negative ? bts_pkg::ST_REJECTED
                                                                  : bts_pkg::ST_BAD_RESP,
                                                sent_ff, blocks_in, counter_ff, committed_ff);
                  end else begin
                     committed_in = pending_ff;
                     sent_in      = sent_ff + {{(SB-LB){1'b0}}, goal_ff};
                     offset_in    = next_offset;
                     counter_in   = counter_ff + 1'b1;
                     if (next_offset >= file_size_ff) begin
                        phase_in     = bts_pkg::PH_IDLE;
                        push.count   = 2'd1;
                        push.item[0] = make_report(bts_pkg::ST_OK, sent_in, blocks_in,
                                                   counter_ff, pending_ff);
                     end else begin
                        fill_in    = '0;
                        goal_in    = (next_rem < {{(SB-LB){1'b0}}, latched_ff})
                                     ? next_rem[LB-1:0] : latched_ff;
                        pending_in = pending_ff;
                        phase_in   = bts_pkg::PH_FILL;
                     end
                  end
               end
            end
            bts_pkg::ACT_FAIL: begin
               if (phase_ff == bts_pkg::PH_FILL) begin
                  phase_in     = bts_pkg::PH_IDLE;
                  push.count   = 2'd1;
                  push.item[0] = make_report(bts_pkg::ST_READ_FAILED, sent_ff, blocks_ff,
                                             last_cnt_ff, committed_ff);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bts_pkg::PH_IDLE;
         counter_ff   <= '0;
         offset_ff    <= '0;
         file_size_ff <= '0;
         fill_ff      <= '0;
         goal_ff      <= '0;
         committed_ff <= '0;
         pending_ff   <= '0;
         sent_ff      <= '0;
         blocks_ff    <= '0;
         last_cnt_ff  <= '0;
         latched_ff   <= '0;
      end else begin
         phase_ff     <= phase_in;
         counter_ff   <= counter_in;
         offset_ff    <= offset_in;
         file_size_ff <= file_size_in;
         fill_ff      <= fill_in;
         goal_ff      <= goal_in;
         committed_ff <= committed_in;
         pending_ff   <= pending_in;
         sent_ff      <= sent_in;
         blocks_ff    <= blocks_in;
         last_cnt_ff  <= last_cnt_in;
         latched_ff   <= latched_in;
      end
   end

endmodule

### rtl/bts_rsp_fifo.sv
`timescale 1ns / 1ps

module bts_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  bts_pkg::rsp_push_type push,
   input  logic                  pop,
   output logic                  not_empty,
   output logic                  room,
   output bts_pkg::rsp_item_type head
);

   localparam int PB = bts_pkg::RSP_PTR_BITS;
   localparam int CB = bts_pkg::RSP_CNT_BITS;

   bts_pkg::rsp_item_type entries_ff [bts_pkg::RSP_DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0] count_ff, count_in;
   logic          do_pop;

   assign not_empty = (count_ff != '0);
   // room for a full burst of results from one transaction
   assign room      = (count_ff <= CB'(bts_pkg::RSP_DEPTH - bts_pkg::MAX_RESULTS));
   assign head      = entries_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   assign wr_ptr_in = wr_ptr_ff + PB'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PB'(do_pop);
   assign count_in  = count_ff + CB'(push.count) - CB'(do_pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < bts_pkg::MAX_RESULTS; i++) begin
         if (i < int'(push.count)) begin
            entries_ff[wr_ptr_ff + PB'(i)] <= push.item[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/bts_checker.sv
`timescale 1ns / 1ps

module bts_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_kind,
   input logic [7:0]                    rsp_frame_byte,
   input logic                          rsp_frame_end,
   input logic [2:0]                    rsp_status,
   input logic [bts_pkg::SIZE_BITS-1:0] rsp_bytes_sent,
   input logic [bts_pkg::CRC_BITS-1:0]  rsp_checksum,
   input logic                          rsp_run_last
);

   // a stalled result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_checksum)
                                 && $stable(rsp_kind) && $stable(rsp_status))
      else $error("stalled result changed");

   // nothing is pending right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // frame bytes carry no totals
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == bts_pkg::KIND_FRAME |->
         rsp_status == bts_pkg::ST_OK && rsp_bytes_sent == '0 && rsp_checksum == '0)
      else $error("frame byte carries totals");

   // a report stands alone and closes its transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == bts_pkg::KIND_REPORT |->
         rsp_run_last && !rsp_frame_end && rsp_frame_byte == '0)
      else $error("malformed report");

   // the end of a frame is always the last result of its transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == bts_pkg::KIND_FRAME && rsp_frame_end |-> rsp_run_last)
      else $error("frame end not last");

endmodule

bind block_transfer_sender_with_crc bts_port_checker u_bts_port_checker (.*);

### tb/bts_checker.sv
`timescale 1ns / 1ps

module bts_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [bts_pkg::SIZE_BITS-1:0]  req_total_size,
   input  logic [7:0]                     req_first_counter,
   input  logic [7:0]                     req_data_byte,
   input  logic [4:0]                     req_resp_length,
   input  logic [7:0]                     req_resp_first,
   input  logic [7:0]                     req_resp_second,
   input  logic                           req_resp_negative,
   input  logic                           req_link_error,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_kind,
   input  logic [7:0]                     rsp_frame_byte,
   input  logic                           rsp_frame_end,
   input  logic [2:0]                     rsp_status,
   input  logic [bts_pkg::SIZE_BITS-1:0]  rsp_bytes_sent,
   input  logic [bts_pkg::SIZE_BITS-1:0]  rsp_blocks_done,
   input  logic [7:0]                     rsp_last_counter,
   input  logic [bts_pkg::CRC_BITS-1:0]   rsp_checksum,
   input  logic                           rsp_run_last,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [bts_pkg::LEN_BITS-1:0]   csr_data,
   output int                             fail_count,
   output int                             outstanding,
   output int                             frames_seen,
   output int                             reports_seen
);
   import bts_pkg::*;

   // register copies
   logic [LEN_BITS-1:0]  cfg_block_len;
   logic                 cfg_claimed;

   // transfer state
   phase_type            stage;
   logic [7:0]           seq_ctr;
   logic [SIZE_BITS-1:0] file_pos;
   logic [SIZE_BITS-1:0] file_len;
   logic [LEN_BITS-1:0]  fill_cnt;
   logic [LEN_BITS-1:0]  fill_goal;
   logic [CRC_BITS-1:0]  crc_acked;
   logic [CRC_BITS-1:0]  crc_run;
   logic [SIZE_BITS-1:0] acked_bytes;
   logic [SIZE_BITS-1:0] block_total;
   logic [7:0]           last_seq;
   logic [LEN_BITS-1:0]  len_latched;

   rsp_item_type frame_report_due[$];
   int fails = 0;
   int frames = 0;
   int reports = 0;

   function automatic logic [CRC_BITS-1:0] crc_step(logic [CRC_BITS-1:0] crc, logic [7:0] b);
      logic [CRC_BITS-1:0] c;
      c = ~crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return ~c;
   endfunction

   function automatic rsp_item_type frame_item(logic [7:0] b, logic last_of_frame);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_FRAME;
      r.frame_byte = b;
      r.frame_end = last_of_frame;
      return r;
   endfunction

   function automatic rsp_item_type report_item(logic [2:0] st, bit zero_totals);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_REPORT;
      r.status = st;
      if (!zero_totals) begin
         r.bytes_sent = acked_bytes;
         r.blocks_done = block_total;
         r.last_counter = last_seq;
         r.checksum = crc_acked;
      end
      return r;
   endfunction

   task automatic open_block();
      logic [SIZE_BITS-1:0] rem;
      rem = file_len - file_pos;
      fill_goal = (rem < {{(SIZE_BITS-LEN_BITS){1'b0}}, len_latched}) ? rem[LEN_BITS-1:0]
                                                                      : len_latched;
      fill_cnt = '0;
      crc_run = crc_acked;
   endtask

   task automatic clear_transfer();
      stage = PH_IDLE;
      seq_ctr = '0;
      file_pos = '0;
      file_len = '0;
      fill_cnt = '0;
      fill_goal = '0;
      crc_acked = '0;
      crc_run = '0;
      acked_bytes = '0;
      block_total = '0;
      last_seq = '0;
      len_latched = '0;
   endtask

   // works out the frame bytes and reports caused by one accepted transaction
   task automatic step_sender();
      rsp_item_type batch[$];
      logic done;
      logic accept;
      case (action_type'(req_action))
         ACT_START: begin
            stage = PH_IDLE;
            if (req_total_size == '0 || cfg_block_len == '0 || cfg_block_len > MAX_BLOCK) begin
               batch.push_back(report_item(ST_BAD_ARG, 1'b1));
            end else if (!cfg_claimed) begin
               batch.push_back(report_item(ST_NOT_CLAIMED, 1'b1));
            end else begin
               seq_ctr = req_first_counter;
               file_pos = '0;
               file_len = req_total_size;
               crc_acked = '0;
               acked_bytes = '0;
               block_total = '0;
               last_seq = '0;
               len_latched = cfg_block_len;
               open_block();
               stage = PH_FILL;
            end
         end
         ACT_DATA: begin
            if (stage == PH_FILL) begin
               if (fill_cnt == '0) begin
                  batch.push_back(frame_item(SID_TRANSFER_DATA, 1'b0));
                  batch.push_back(frame_item(seq_ctr, 1'b0));
               end
               crc_run = crc_step(crc_run, req_data_byte);
               fill_cnt = fill_cnt + 1'b1;
               done = (fill_cnt >= fill_goal);
               batch.push_back(frame_item(req_data_byte, done));
               if (done) stage = PH_WAIT;
            end
         end
         ACT_RESP: begin
            if (stage == PH_WAIT) begin
               accept = !req_link_error && req_resp_length >= 5'd1 &&
                        req_resp_first == SID_TRANSFER_DATA_POS &&
                        !(req_resp_length >= 5'd2 && req_resp_second != seq_ctr) &&
                        !req_resp_negative;
               block_total = block_total + 1'b1;
               last_seq = seq_ctr;
               if (!accept) begin
                  stage = PH_IDLE;
                  batch.push_back(report_item(req_resp_negative ? ST_REJECTED : ST_BAD_RESP,
                                              1'b0));
               end else begin
                  crc_acked = crc_run;
                  acked_bytes = acked_bytes + {{(SIZE_BITS-LEN_BITS){1'b0}}, fill_goal};
                  file_pos = file_pos + {{(SIZE_BITS-LEN_BITS){1'b0}}, fill_goal};
                  seq_ctr = seq_ctr + 8'd1;
                  if (file_pos >= file_len) begin
                     stage = PH_IDLE;
                     batch.push_back(report_item(ST_OK, 1'b0));
                  end else begin
                     open_block();
                     stage = PH_FILL;
                  end
               end
            end
         end
         ACT_FAIL: begin
            if (stage == PH_FILL) begin
               stage = PH_IDLE;
               batch.push_back(report_item(ST_READ_FAILED, 1'b0));
            end
         end
         default: ;
      endcase
      if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
      foreach (batch[i]) frame_report_due.push_back(batch[i]);
   endtask

   function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      int errs;
      if (reset) begin
         cfg_block_len = BLOCK_LENGTH_RESET;
         cfg_claimed = 1'b0;
         clear_transfer();
         frame_report_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BLOCK_LENGTH) cfg_block_len = csr_data;
            else cfg_claimed = csr_data[0];
         end
         // compare first: a result never belongs to a transaction taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (frame_report_due.size() == 0) begin
               $error("result with no transaction pending: kind %0d byte 0x%0h status %0d",
                      rsp_kind, rsp_frame_byte, rsp_status);
               fails++;
            end else begin
               want = frame_report_due.pop_front();
               errs = field_diff("kind", want.kind, rsp_kind)
                    + field_diff("frame_byte", want.frame_byte, rsp_frame_byte)
                    + field_diff("frame_end", want.frame_end, rsp_frame_end)
                    + field_diff("status", want.status, rsp_status)
                    + field_diff("bytes_sent", want.bytes_sent, rsp_bytes_sent)
                    + field_diff("blocks_done", want.blocks_done, rsp_blocks_done)
                    + field_diff("last_counter", want.last_counter, rsp_last_counter)
                    + field_diff("checksum", want.checksum, rsp_checksum)
                    + field_diff("run_last", want.run_last, rsp_run_last);
               if (errs != 0) fails++;
               if (want.kind == KIND_FRAME) frames++;
               else reports++;
            end
         end
         if (req_valid && !req_stall) step_sender();
      end
      outstanding <= frame_report_due.size();
      fail_count <= fails;
      frames_seen <= frames;
      reports_seen <= reports;
   end

endmodule

### tb/tb_block_transfer_sender_with_crc.sv
`timescale 1ns / 1ps

module tb_block_transfer_sender_with_crc;
   import bts_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 160;

   typedef struct packed {
      action_type            action;
      logic [SIZE_BITS-1:0]  total_size;
      logic [7:0]            first_counter;
      logic [7:0]            data_byte;
      logic [4:0]            resp_length;
      logic [7:0]            resp_first;
      logic [7:0]            resp_second;
      logic                  resp_negative;
      logic                  link_error;
   } sender_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_action;
   logic [SIZE_BITS-1:0]  req_total_size;
   logic [7:0]            req_first_counter;
   logic [7:0]            req_data_byte;
   logic [4:0]            req_resp_length;
   logic [7:0]            req_resp_first;
   logic [7:0]            req_resp_second;
   logic                  req_resp_negative;
   logic                  req_link_error;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_kind;
   logic [7:0]            rsp_frame_byte;
   logic                  rsp_frame_end;
   logic [2:0]            rsp_status;
   logic [SIZE_BITS-1:0]  rsp_bytes_sent;
   logic [SIZE_BITS-1:0]  rsp_blocks_done;
   logic [7:0]            rsp_last_counter;
   logic [CRC_BITS-1:0]   rsp_checksum;
   logic                  rsp_run_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_index;
   logic [LEN_BITS-1:0]   csr_data;

   int fail_count;
   int outstanding;
   int frames_seen;
   int reports_seen;

   int cycle_count = 0;
   int sent_total = 0;
   int starts_sent = 0;
   int counted = 0;
   bit calm = 1'b0;
   logic [LEN_BITS-1:0] cur_len = BLOCK_LENGTH_RESET;
   logic cur_claim = 1'b0;

   block_transfer_sender_with_crc dut (.*);
   bts_checker u_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !calm && ($urandom_range(99) < 26);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_block_transfer_sender_with_crc: FAIL");
         $finish;
      end
   end

   // every field random, the caller overrides what the action uses
   function automatic sender_req_type mk(action_type a);
      sender_req_type r;
      r.action = a;
      r.total_size = SIZE_BITS'($urandom);
      r.first_counter = 8'($urandom);
      r.data_byte = 8'($urandom);
      r.resp_length = 5'($urandom_range(16));
      r.resp_first = 8'($urandom);
      r.resp_second = 8'($urandom);
      r.resp_negative = 1'($urandom);
      r.link_error = 1'($urandom);
      return r;
   endfunction

   task automatic send(input sender_req_type r);
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= r.action;
      req_total_size <= r.total_size;
      req_first_counter <= r.first_counter;
      req_data_byte <= r.data_byte;
      req_resp_length <= r.resp_length;
      req_resp_first <= r.resp_first;
      req_resp_second <= r.resp_second;
      req_resp_negative <= r.resp_negative;
      req_link_error <= r.link_error;
      do @(posedge clock); while (req_stall);
      sent_total++;
   endtask

   task automatic send_start(input logic [SIZE_BITS-1:0] size, input logic [7:0] seq);
      sender_req_type r;
      r = mk(ACT_START);
      r.total_size = size;
      r.first_counter = seq;
      send(r);
      starts_sent++;
   endtask

   task automatic send_data(input logic [7:0] b);
      sender_req_type r;
      r = mk(ACT_DATA);
      r.data_byte = b;
      send(r);
   endtask

   task automatic send_resp(input logic [4:0] len, input logic [7:0] first,
                            input logic [7:0] second, input logic neg, input logic lerr);
      sender_req_type r;
      r = mk(ACT_RESP);
      r.resp_length = len;
      r.resp_first = first;
      r.resp_second = second;
      r.resp_negative = neg;
      r.link_error = lerr;
      send(r);
   endtask

   // hold the sender until every predicted result is out, plus the block's latency
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [LEN_BITS-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_BLOCK_LENGTH) cur_len = value;
      else cur_claim = value[0];
   endtask

   // one well-formed transfer with random content and occasional faults
   task automatic run_transfer();
      logic [SIZE_BITS-1:0] size;
      logic [SIZE_BITS-1:0] left;
      logic [LEN_BITS-1:0]  goal;
      logic [7:0]           seq;
      logic [7:0]           echo;
      logic [4:0]           rlen;
      int pick;
      int bytes_in;
      int abort_at;
      pick = $urandom_range(99);
      if (pick < 4) size = '0;
      else if (pick < 14) size = SIZE_BITS'($urandom);
      else size = SIZE_BITS'($urandom_range(1, 30));
      seq = ($urandom_range(99) < 15) ? 8'd255 : 8'($urandom);
      send_start(size, seq);
      counted++;
      if (size == '0 || cur_len == '0 || cur_len > MAX_BLOCK || !cur_claim) return;
      // huge files are cut short by a read failure
      abort_at = (size > 64) ? $urandom_range(0, 20) : -1;
      bytes_in = 0;
      left = size;
      while (left != '0) begin
         goal = (left < {{(SIZE_BITS-LEN_BITS){1'b0}}, cur_len}) ? left[LEN_BITS-1:0] : cur_len;
         for (int k = 0; k < goal; k++) begin
            if (bytes_in == abort_at || $urandom_range(99) < 3) begin
               send(mk(ACT_FAIL));
               counted++;
               return;
            end
            // leave it open: the next start lands on a running transfer
            if ($urandom_range(99) < 2) return;
            if ($urandom_range(99) < 5) send(mk(ACT_RESP));
            send_data(8'($urandom));
            counted++;
            bytes_in++;
         end
         if ($urandom_range(99) < 5) send(mk($urandom_range(1) ? ACT_DATA : ACT_FAIL));
         rlen = $urandom_range(1) ? 5'd1 : 5'($urandom_range(2, 16));
         echo = (rlen >= 5'd2) ? seq : 8'($urandom);
         pick = $urandom_range(99);
         counted++;
         if (pick >= 82) begin
            case ($urandom_range(4))
               0: send_resp(rlen, SID_TRANSFER_DATA_POS, echo, 1'($urandom), 1'b1);
               1: send_resp(5'd0, SID_TRANSFER_DATA_POS, echo, 1'b0, 1'b0);
               2: send_resp(rlen, SID_TRANSFER_DATA_POS ^ (8'd1 << $urandom_range(7)),
                            echo, 1'b0, 1'b0);
               3: send_resp(5'($urandom_range(2, 16)), SID_TRANSFER_DATA_POS,
                            seq ^ (8'd1 << $urandom_range(7)), 1'b0, 1'b0);
               default: send_resp(rlen, SID_TRANSFER_DATA_POS, echo, 1'b1, 1'b0);
            endcase
            return;
         end
         send_resp(rlen, SID_TRANSFER_DATA_POS, echo, 1'b0, 1'b0);
         left = left - {{(SIZE_BITS-LEN_BITS){1'b0}}, goal};
         seq = seq + 8'd1;
      end
   endtask

   initial begin
      logic [7:0] seq;
      int pick;
      logic [LEN_BITS-1:0] len;
      req_valid = 1'b0;
      req_action = ACT_START;
      req_total_size = '0;
      req_first_counter = '0;
      req_data_byte = '0;
      req_resp_length = '0;
      req_resp_first = '0;
      req_resp_second = '0;
      req_resp_negative = 1'b0;
      req_link_error = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_BLOCK_LENGTH;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // claim is clear after reset
      send_start(24'd5, 8'd1);
      // zero size is refused before the claim is looked at
      send_start(24'd0, 8'd1);
      // nothing running: these are ignored
      send_data(8'hA5);
      send_resp(5'd2, SID_TRANSFER_DATA_POS, 8'd0, 1'b0, 1'b0);
      send(mk(ACT_FAIL));
      write_csr(CSR_CLAIMED, 13'd1);
      write_csr(CSR_BLOCK_LENGTH, 13'd0);
      send_start(24'd3, 8'd0);
      write_csr(CSR_BLOCK_LENGTH, 13'd4097);
      send_start(24'd3, 8'd0);
      write_csr(CSR_BLOCK_LENGTH, 13'd2);
      // counter wraps from 255 after the first block
      send_start(24'd3, 8'd255);
      send_data(8'h00);
      send_data(8'hFF);
      send_resp(5'd2, SID_TRANSFER_DATA_POS, 8'd255, 1'b0, 1'b0);
      send_data(8'h5A);
      send_resp(5'd1, SID_TRANSFER_DATA_POS, 8'h13, 1'b0, 1'b0);
      // read failure in the middle of a block
      send_start(24'hFFFFFF, 8'd0);
      send_data(8'h11);
      send(mk(ACT_FAIL));
      // link error with the negative flag
      send_start(24'd4, 8'd7);
      send_data(8'h80);
      send_data(8'h01);
      send_resp(5'd16, SID_TRANSFER_DATA_POS, 8'd7, 1'b1, 1'b1);
      // length changed after start: the latched one still applies
      send_start(24'd2, 8'd9);
      write_csr(CSR_BLOCK_LENGTH, 13'd1);
      send_data(8'h3C);
      send_data(8'hC3);
      send_resp(5'd2, SID_TRANSFER_DATA_POS, 8'd10, 1'b0, 1'b0);
      // a new start drops the running transfer
      write_csr(CSR_BLOCK_LENGTH, 13'd3);
      send_start(24'd5, 8'd20);
      send_data(8'h42);
      send_start(24'd1, 8'd40);
      send_data(8'h99);
      send_resp(5'd0, SID_TRANSFER_DATA_POS, 8'd40, 1'b0, 1'b0);

      // the largest length is accepted, a short file fits in one block
      write_csr(CSR_BLOCK_LENGTH, MAX_BLOCK);
      seq = 8'($urandom);
      send_start(24'd3, seq);
      repeat (3) send_data(8'($urandom));
      send_resp(5'd2, SID_TRANSFER_DATA_POS, seq, 1'b0, 1'b0);

      while (counted < RANDOM_ITEMS) begin
         calm = (counted >= 60 && counted < 110);
         if ($urandom_range(99) < 30) begin
            pick = $urandom_range(99);
            if (pick < 4) len = 13'd0;
            else if (pick < 7) len = 13'd4097;
            else if (pick < 9) len = 13'h1FFF;
            else if (pick < 16) len = MAX_BLOCK;
            else if (pick < 30) len = 13'd1;
            else len = LEN_BITS'($urandom_range(2, 12));
            write_csr(CSR_BLOCK_LENGTH, len);
            write_csr(CSR_CLAIMED, {12'($urandom), ($urandom_range(99) >= 15)});
         end else if ($urandom_range(99) < 5) begin
            drain_results();
         end
         run_transfer();
      end
      calm = 1'b0;

      drain_results();
      repeat (20) @(posedge clock);
      $display("covered %0d transactions, %0d of them starts, over block lengths 0 to 8191",
               sent_total, starts_sent);
      $display("checked %0d frame bytes and %0d status reports", frames_seen, reports_seen);
      if (fail_count == 0) begin
         $display("tb_block_transfer_sender_with_crc: PASS");
      end else begin
         $display("tb_block_transfer_sender_with_crc: FAIL");
      end
      $finish;
   end

endmodule

### block_transfer_sender_with_crc.f
rtl/bts_pkg.sv
rtl/bts_core.sv
rtl/bts_rsp_fifo.sv
rtl/block_transfer_sender_with_crc.sv
rtl/bts_checker.sv
tb/bts_checker.sv
tb/tb_block_transfer_sender_with_crc.sv
